>>> sv/vna_pkg.sv
// Shared types, constants and codes for the vertex normal accumulator.
package vna_pkg;

  localparam int IDX_W            = 12;
  localparam int CRD_W            = 24;
  localparam int SUM_W            = 24;
  localparam int UNIT_W           = 16;
  localparam int VEC_W            = 51;
  localparam int UNIT_ONE         = 16384;
  localparam int ADDR_SPAN        = 4096;
  localparam int MAX_VERTICES_DEF = 4096;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_READ     = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_TRIANGLE,
    CMD_READ,
    CMD_READ_MISS
  } cmd_kind_t;

  typedef logic [2:0][CRD_W-1:0] vec3_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [IDX_W-1:0]        a;
    logic [IDX_W-1:0]        b;
    logic [IDX_W-1:0]        c;
    vec3_t                   pos;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]         vertex;
    logic signed [UNIT_W-1:0] ux;
    logic signed [UNIT_W-1:0] uy;
    logic signed [UNIT_W-1:0] uz;
    logic                     zero_sum;
  } result_t;

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } unit_req_t;

  typedef struct packed {
    logic                     done;
    logic                     nz;
    logic signed [UNIT_W-1:0] ux;
    logic signed [UNIT_W-1:0] uy;
    logic signed [UNIT_W-1:0] uz;
  } unit_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_POS,
    BK_EDGE,
    BK_CROSS,
    BK_SUMRD,
    BK_SUMLD,
    BK_UGO,
    BK_UWAIT,
    BK_ACC,
    BK_EMIT
  } back_state_t;

  typedef enum logic [2:0] {
    UN_IDLE,
    UN_SHIFT,
    UN_SQUARE,
    UN_ROOT,
    UN_DIVSET,
    UN_DIV,
    UN_DONE
  } unit_state_t;

endpackage

>>> sv/vna_fifo.sv
// Small register queue with full/empty flags.
module vna_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (PW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

>>> sv/vna_front.sv
// Front end: accepts input beats, drops ignored ones, queues commands.
module vna_front #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      opcode,
  input  logic [vna_pkg::IDX_W-1:0]       first_corner,
  input  logic [vna_pkg::IDX_W-1:0]       second_corner,
  input  logic [vna_pkg::IDX_W-1:0]       third_corner,
  input  logic signed [vna_pkg::CRD_W-1:0] coord_x,
  input  logic signed [vna_pkg::CRD_W-1:0] coord_y,
  input  logic signed [vna_pkg::CRD_W-1:0] coord_z,
  output vna_pkg::cmd_t                   cmd,
  output logic                            cmd_valid,
  input  logic                            cmd_pop
);

  localparam int CW = $bits(vna_pkg::cmd_t);

  vna_pkg::cmd_t  cls;
  logic           keep;
  logic           ra, rb, rc;
  logic           q_empty;
  logic [CW-1:0]  q_dout;

  assign ra = 32'(first_corner)  < 32'(MAX_VERTICES);
  assign rb = 32'(second_corner) < 32'(MAX_VERTICES);
  assign rc = 32'(third_corner)  < 32'(MAX_VERTICES);

  always_comb begin
    cls.kind   = vna_pkg::CMD_WRITE;
    cls.a      = first_corner;
    cls.b      = second_corner;
    cls.c      = third_corner;
    cls.pos[0] = coord_x;
    cls.pos[1] = coord_y;
    cls.pos[2] = coord_z;
    keep       = 1'b0;
    unique case (vna_pkg::opcode_t'(opcode))
      vna_pkg::OP_WRITE: begin
        keep = ra;
      end
      vna_pkg::OP_TRIANGLE: begin
        cls.kind = vna_pkg::CMD_TRIANGLE;
        keep     = ra && rb && rc;
      end
      vna_pkg::OP_READ: begin
        cls.kind = ra ? vna_pkg::CMD_READ : vna_pkg::CMD_READ_MISS;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  vna_fifo #(
    .W     (CW),
    .DEPTH (vna_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push && keep),
    .din   (cls),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign cmd       = q_dout;
  assign cmd_valid = !q_empty;

endmodule

>>> sv/vna_unit.sv
// Normalizer: scales a vector to a Q1.14 unit vector, bit-serial root and divide.
module vna_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  vna_pkg::unit_req_t req,
  output vna_pkg::unit_rsp_t rsp
);

  localparam int VW    = vna_pkg::VEC_W;
  localparam int NW    = 30;
  localparam int SQ_W  = 62;
  localparam int RT_W  = 63;
  localparam int LEN_W = 31;
  localparam int DIV_W = 46;
  localparam int Q_W   = vna_pkg::UNIT_W;

  vna_pkg::unit_state_t state_r, state_nxt;

  logic signed [VW-1:0] c_in [3];
  logic [VW-1:0]        mag_in [3];
  logic                 neg_in [3];
  logic [VW-1:0]        m_in;

  logic [VW-1:0]        mag_r [3];
  logic                 neg_r [3];
  logic [VW-1:0]        m_r;
  logic [3:0]           cnt_r;
  logic [1:0]           comp_r;
  logic [2*NW-1:0]      prod_r;
  logic [SQ_W-1:0]      sq_r;
  logic [RT_W-1:0]      v_r, root_r, bit_r;
  logic [DIV_W-1:0]     rem_r, den_r;
  logic [Q_W-1:0]       q_r;
  logic signed [Q_W-1:0] u_r [3];
  logic                 nz_r;

  logic [1:0]           sq_sel;
  logic [NW-1:0]        sq_op;
  logic [RT_W-1:0]      trial;
  logic                 root_ge;
  logic [LEN_W-1:0]     len;
  logic [NW-1:0]        div_mag;
  logic                 div_ge;
  logic [Q_W-1:0]       q_nxt, q_cl;
  logic signed [Q_W-1:0] u_val;
  logic                 m_high, in_band;

  always_comb begin
    c_in[0] = req.x;
    c_in[1] = req.y;
    c_in[2] = req.z;
    m_in    = '0;
    for (int k = 0; k < 3; k++) begin
      neg_in[k] = c_in[k][VW-1];
      mag_in[k] = neg_in[k] ? VW'(~c_in[k] + 1'b1) : VW'(c_in[k]);
      if (mag_in[k] > m_in) begin
        m_in = mag_in[k];
      end
    end
  end

  assign m_high  = (m_r[VW-1:NW] != '0);
  assign in_band = !m_high && m_r[NW-1];
  assign sq_sel  = (cnt_r < 4'd3) ? cnt_r[1:0] : 2'd0;
  assign sq_op   = mag_r[sq_sel][NW-1:0];
  assign trial   = root_r + bit_r;
  assign root_ge = (v_r >= trial);
  assign len     = root_r[LEN_W-1:0];
  assign div_mag = mag_r[comp_r][NW-1:0];
  assign div_ge  = (rem_r >= den_r);
  assign q_nxt   = {q_r[Q_W-2:0], div_ge};
  assign q_cl    = (q_nxt > Q_W'(vna_pkg::UNIT_ONE)) ? Q_W'(vna_pkg::UNIT_ONE) : q_nxt;
  assign u_val   = neg_r[comp_r] ? -signed'(q_cl) : signed'(q_cl);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vna_pkg::UN_IDLE: begin
        if (req.start) begin
          state_nxt = (m_in == '0) ? vna_pkg::UN_DONE : vna_pkg::UN_SHIFT;
        end
      end
      vna_pkg::UN_SHIFT: begin
        if (in_band) state_nxt = vna_pkg::UN_SQUARE;
      end
      vna_pkg::UN_SQUARE: begin
        if (cnt_r == 4'd3) state_nxt = vna_pkg::UN_ROOT;
      end
      vna_pkg::UN_ROOT: begin
        if (bit_r[0]) state_nxt = vna_pkg::UN_DIVSET;
      end
      vna_pkg::UN_DIVSET: begin
        state_nxt = vna_pkg::UN_DIV;
      end
      vna_pkg::UN_DIV: begin
        if (cnt_r == 4'd15) begin
          state_nxt = (comp_r == 2'd2) ? vna_pkg::UN_DONE : vna_pkg::UN_DIVSET;
        end
      end
      vna_pkg::UN_DONE: begin
        state_nxt = vna_pkg::UN_IDLE;
      end
      default: begin
        state_nxt = vna_pkg::UN_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.done = (state_r == vna_pkg::UN_DONE);
    rsp.nz   = nz_r;
    rsp.ux   = u_r[0];
    rsp.uy   = u_r[1];
    rsp.uz   = u_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vna_pkg::UN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      vna_pkg::UN_IDLE: begin
        if (req.start) begin
          for (int k = 0; k < 3; k++) begin
            mag_r[k] <= mag_in[k];
            neg_r[k] <= neg_in[k];
            u_r[k]   <= '0;
          end
          m_r  <= m_in;
          nz_r <= 1'b0;
        end
      end
      vna_pkg::UN_SHIFT: begin
        if (m_high) begin
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
          m_r <= m_r >> 1;
        end else if (!m_r[NW-1]) begin
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
          m_r <= m_r << 1;
        end
        cnt_r <= '0;
        sq_r  <= '0;
      end
      vna_pkg::UN_SQUARE: begin
        prod_r <= sq_op * sq_op;
        if (cnt_r != '0) sq_r <= sq_r + SQ_W'(prod_r);
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 4'd3) begin
          v_r    <= RT_W'(sq_r + SQ_W'(prod_r));
          root_r <= '0;
          bit_r  <= RT_W'(1) << (RT_W-1);
        end
      end
      vna_pkg::UN_ROOT: begin
        if (root_ge) begin
          v_r    <= v_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        comp_r <= '0;
      end
      vna_pkg::UN_DIVSET: begin
        rem_r <= DIV_W'({div_mag, 14'b0}) + DIV_W'(len >> 1);
        den_r <= DIV_W'(len) << (Q_W-1);
        q_r   <= '0;
        cnt_r <= '0;
      end
      vna_pkg::UN_DIV: begin
        if (div_ge) rem_r <= rem_r - den_r;
        den_r <= den_r >> 1;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 4'd15) begin
          u_r[comp_r] <= u_val;
          comp_r      <= comp_r + 1'b1;
          if (comp_r == 2'd2) nz_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/vna_back.sv
// Back end: position and sum stores, cross product, accumulate and readout.
module vna_back #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vna_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  output vna_pkg::unit_req_t unit_req,
  input  vna_pkg::unit_rsp_t unit_rsp,
  output vna_pkg::result_t   res,
  output logic               res_push,
  input  logic               res_full
);

  localparam int DEPTH = (MAX_VERTICES < vna_pkg::ADDR_SPAN) ? MAX_VERTICES
                                                             : vna_pkg::ADDR_SPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = vna_pkg::IDX_W;
  localparam int SW    = vna_pkg::SUM_W;
  localparam int UW    = vna_pkg::UNIT_W;
  localparam int EW    = vna_pkg::CRD_W + 1;
  localparam int VW    = vna_pkg::VEC_W;

  vna_pkg::back_state_t state_r, state_nxt;

  vna_pkg::vec3_t pos_mem [DEPTH];
  vna_pkg::vec3_t sum_mem [DEPTH];
  vna_pkg::vec3_t pos_rd_r, sum_rd_r, pos_wd, sum_wd;
  logic [AW-1:0]  pos_ra, pos_wa, sum_ra, sum_wa;
  logic           pos_we, sum_we;

  vna_pkg::cmd_t    cmd_r;
  vna_pkg::result_t res_r;
  logic [2:0]       cnt_r;
  vna_pkg::vec3_t   p_r [3];
  logic signed [EW-1:0]   e1_r [3];
  logic signed [EW-1:0]   e2_r [3];
  logic signed [2*EW-1:0] prod_r;
  logic signed [VW-1:0]   n_r [3];
  logic signed [UW-1:0]   uvec_r [3];
  logic signed [EW-1:0]   opa, opb;
  logic [2:0]             acc_j;

  function automatic logic [IW-1:0] corner(vna_pkg::cmd_t c, logic [1:0] s);
    logic [IW-1:0] r;
    case (s)
      2'd0:    r = c.a;
      2'd1:    r = c.b;
      default: r = c.c;
    endcase
    return r;
  endfunction

  function automatic logic [SW-1:0] sat_add(logic [SW-1:0] s, logic [UW-1:0] u);
    logic signed [SW:0] t;
    logic [SW-1:0]      r;
    t = signed'({s[SW-1], s}) + signed'({{(SW+1-UW){u[UW-1]}}, u});
    if (t[SW] != t[SW-1]) begin
      r = t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      r = t[SW-1:0];
    end
    return r;
  endfunction

  assign acc_j = cnt_r - 1'b1;

  always_comb begin
    case (cnt_r)
      3'd0:    begin opa = e1_r[1]; opb = e2_r[2]; end
      3'd1:    begin opa = e1_r[2]; opb = e2_r[1]; end
      3'd2:    begin opa = e1_r[2]; opb = e2_r[0]; end
      3'd3:    begin opa = e1_r[0]; opb = e2_r[2]; end
      3'd4:    begin opa = e1_r[0]; opb = e2_r[1]; end
      default: begin opa = e1_r[1]; opb = e2_r[0]; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vna_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            vna_pkg::CMD_TRIANGLE: state_nxt = vna_pkg::BK_POS;
            vna_pkg::CMD_READ:     state_nxt = vna_pkg::BK_SUMRD;
            vna_pkg::CMD_READ_MISS: state_nxt = vna_pkg::BK_EMIT;
            default:               state_nxt = vna_pkg::BK_IDLE;
          endcase
        end
      end
      vna_pkg::BK_POS:   if (cnt_r == 3'd3) state_nxt = vna_pkg::BK_EDGE;
      vna_pkg::BK_EDGE:  state_nxt = vna_pkg::BK_CROSS;
      vna_pkg::BK_CROSS: if (cnt_r == 3'd6) state_nxt = vna_pkg::BK_UGO;
      vna_pkg::BK_SUMRD: state_nxt = vna_pkg::BK_SUMLD;
      vna_pkg::BK_SUMLD: state_nxt = vna_pkg::BK_UGO;
      vna_pkg::BK_UGO:   state_nxt = vna_pkg::BK_UWAIT;
      vna_pkg::BK_UWAIT: begin
        if (unit_rsp.done) begin
          if (cmd_r.kind == vna_pkg::CMD_TRIANGLE) begin
            state_nxt = unit_rsp.nz ? vna_pkg::BK_ACC : vna_pkg::BK_IDLE;
          end else begin
            state_nxt = vna_pkg::BK_EMIT;
          end
        end
      end
      vna_pkg::BK_ACC:   if (cnt_r == 3'd5) state_nxt = vna_pkg::BK_IDLE;
      vna_pkg::BK_EMIT:  if (!res_full) state_nxt = vna_pkg::BK_IDLE;
      default:           state_nxt = vna_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop        = 1'b0;
    pos_we         = 1'b0;
    pos_wa         = AW'(cmd.a);
    pos_wd         = cmd.pos;
    pos_ra         = AW'(corner(cmd_r, cnt_r[1:0]));
    sum_we         = 1'b0;
    sum_wa         = AW'(cmd.a);
    sum_wd         = '0;
    sum_ra         = AW'(cmd_r.a);
    unit_req.start = 1'b0;
    unit_req.x     = n_r[0];
    unit_req.y     = n_r[1];
    unit_req.z     = n_r[2];
    res_push       = 1'b0;
    unique case (state_r)
      vna_pkg::BK_IDLE: begin
        cmd_pop = cmd_valid;
        if (cmd_valid && cmd.kind == vna_pkg::CMD_WRITE) begin
          pos_we = 1'b1;
          sum_we = 1'b1;
        end
      end
      vna_pkg::BK_UGO: begin
        unit_req.start = 1'b1;
      end
      vna_pkg::BK_ACC: begin
        sum_ra = AW'(corner(cmd_r, cnt_r[2:1]));
        if (cnt_r[0]) begin
          sum_we = 1'b1;
          sum_wa = AW'(corner(cmd_r, cnt_r[2:1]));
          for (int k = 0; k < 3; k++) begin
            sum_wd[k] = sat_add(sum_rd_r[k], uvec_r[k]);
          end
        end
      end
      vna_pkg::BK_EMIT: begin
        res_push = !res_full;
      end
      default: begin
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vna_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd_r <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      vna_pkg::BK_IDLE: begin
        cnt_r <= '0;
        if (cmd_valid) begin
          cmd_r           <= cmd;
          res_r.vertex    <= cmd.a;
          res_r.ux        <= '0;
          res_r.uy        <= '0;
          res_r.uz        <= '0;
          res_r.zero_sum  <= 1'b1;
        end
      end
      vna_pkg::BK_POS: begin
        if (cnt_r != '0) p_r[cnt_r[1:0] - 2'd1] <= pos_rd_r;
        cnt_r <= cnt_r + 1'b1;
      end
      vna_pkg::BK_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1_r[k] <= EW'(signed'(p_r[1][k])) - EW'(signed'(p_r[0][k]));
          e2_r[k] <= EW'(signed'(p_r[2][k])) - EW'(signed'(p_r[0][k]));
        end
        cnt_r <= '0;
      end
      vna_pkg::BK_CROSS: begin
        prod_r <= opa * opb;
        if (cnt_r != '0) begin
          if (acc_j[0]) n_r[acc_j[2:1]] <= n_r[acc_j[2:1]] - VW'(prod_r);
          else          n_r[acc_j[2:1]] <= VW'(prod_r);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      vna_pkg::BK_SUMLD: begin
        for (int k = 0; k < 3; k++) n_r[k] <= VW'(signed'(sum_rd_r[k]));
      end
      vna_pkg::BK_UWAIT: begin
        cnt_r <= '0;
        if (unit_rsp.done) begin
          uvec_r[0]      <= unit_rsp.ux;
          uvec_r[1]      <= unit_rsp.uy;
          uvec_r[2]      <= unit_rsp.uz;
          res_r.ux       <= unit_rsp.ux;
          res_r.uy       <= unit_rsp.uy;
          res_r.uz       <= unit_rsp.uz;
          res_r.zero_sum <= !unit_rsp.nz;
        end
      end
      vna_pkg::BK_ACC: begin
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_push_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> state_r == vna_pkg::BK_EMIT)
    else $error("result pushed outside emit");

  a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> state_r == vna_pkg::BK_IDLE)
    else $error("command popped while busy");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    unit_rsp.done |-> state_r == vna_pkg::BK_UWAIT)
    else $error("normalizer finished while not awaited");

  a_start_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    unit_req.start |=> state_r == vna_pkg::BK_UWAIT)
    else $error("normalizer start not followed by wait");

endmodule

>>> sv/vertex_normal_accumulator_top.sv
// Back-end work per item: a zero-sum readout skips the normalizer's search, root and
// divides, an out-of-range readout skips the normalizer, and a degenerate face skips the
// accumulate. The normalizer's one-bit-per-cycle shift search, sum of squares, 32-step
// square root and three divisions set the item time, plus three position reads and three
// sum RMWs. One item is worked at a time; two-entry queues sit on input and result sides.
// Reset clears control and queues only; stores hold garbage until written.
module vertex_normal_accumulator_top #(
  parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        in_opcode,
  input  logic [vna_pkg::IDX_W-1:0]         in_first_corner,
  input  logic [vna_pkg::IDX_W-1:0]         in_second_corner,
  input  logic [vna_pkg::IDX_W-1:0]         in_third_corner,
  input  logic signed [vna_pkg::CRD_W-1:0]  in_coord_x,
  input  logic signed [vna_pkg::CRD_W-1:0]  in_coord_y,
  input  logic signed [vna_pkg::CRD_W-1:0]  in_coord_z,
  output logic                              empty,
  input  logic                              pop,
  output logic [vna_pkg::IDX_W-1:0]         out_read_vertex,
  output logic signed [vna_pkg::UNIT_W-1:0] out_unit_x,
  output logic signed [vna_pkg::UNIT_W-1:0] out_unit_y,
  output logic signed [vna_pkg::UNIT_W-1:0] out_unit_z,
  output logic                              out_zero_sum
);

  localparam int RW = $bits(vna_pkg::result_t);

  vna_pkg::cmd_t      cmd;
  logic               cmd_valid, cmd_pop;
  vna_pkg::unit_req_t unit_req;
  vna_pkg::unit_rsp_t unit_rsp;
  vna_pkg::result_t   res, res_out;
  logic               res_push, res_full;
  logic [RW-1:0]      res_dout;

  vna_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .opcode        (in_opcode),
    .first_corner  (in_first_corner),
    .second_corner (in_second_corner),
    .third_corner  (in_third_corner),
    .coord_x       (in_coord_x),
    .coord_y       (in_coord_y),
    .coord_z       (in_coord_z),
    .cmd           (cmd),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop)
  );

  vna_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (unit_req),
    .rsp   (unit_rsp)
  );

  vna_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .unit_req  (unit_req),
    .unit_rsp  (unit_rsp),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  vna_fifo #(
    .W     (RW),
    .DEPTH (vna_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign res_out         = res_dout;
  assign out_read_vertex = res_out.vertex;
  assign out_unit_x      = res_out.ux;
  assign out_unit_y      = res_out.uy;
  assign out_unit_z      = res_out.uz;
  assign out_zero_sum    = res_out.zero_sum;

endmodule
